FILE: hw/rtl/dlrp_pkg.sv
// Package: shared types, codes and character helpers of the delay list parser.
`timescale 1ns / 1ps
`default_nettype none
package dlrp_pkg;

  localparam int STORE_DEPTH = 64;
  localparam int AW          = $clog2(STORE_DEPTH);
  localparam int CW          = AW + 1;

  localparam logic [7:0] ENTRY_MAX     = 8'h40;
  localparam logic [7:0] ENTRY_SPECIAL = 8'h80;

  localparam logic REQ_CHAR = 1'b0;
  localparam logic REQ_END  = 1'b1;

  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_OPEN  = 8'h7B;
  localparam logic [7:0] CH_CLOSE = 8'h7D;

  localparam logic [1:0] PH_EXPECT      = 2'd0;
  localparam logic [1:0] PH_NUMBER      = 2'd1;
  localparam logic [1:0] PH_AFTER_NUM   = 2'd2;
  localparam logic [1:0] PH_AFTER_CLOSE = 2'd3;

  localparam logic [2:0] TK_NONE  = 3'd0;
  localparam logic [2:0] TK_DIGIT = 3'd1;
  localparam logic [2:0] TK_OPEN  = 3'd2;
  localparam logic [2:0] TK_CLOSE = 3'd3;
  localparam logic [2:0] TK_COMMA = 3'd4;

  localparam logic [1:0] PF_NONE    = 2'd0;
  localparam logic [1:0] PF_ZERO    = 2'd1;
  localparam logic [1:0] PF_HEXWAIT = 2'd2;
  localparam logic [1:0] PF_DIGITS  = 2'd3;

  localparam logic [1:0] BASE_DEC = 2'd0;
  localparam logic [1:0] BASE_OCT = 2'd1;
  localparam logic [1:0] BASE_HEX = 2'd2;

  localparam logic [3:0] ERR_OK          = 4'd0;
  localparam logic [3:0] ERR_COMMA       = 4'd1;
  localparam logic [3:0] ERR_BAD_NUMBER  = 4'd2;
  localparam logic [3:0] ERR_CLOSE       = 4'd3;
  localparam logic [3:0] ERR_NO_COMMA    = 4'd4;
  localparam logic [3:0] ERR_RANGE       = 4'd5;
  localparam logic [3:0] ERR_TRAILING    = 4'd6;
  localparam logic [3:0] ERR_NO_COUNT    = 4'd7;
  localparam logic [3:0] ERR_EMPTY_GROUP = 4'd8;
  localparam logic [3:0] ERR_TOO_MANY    = 4'd9;
  localparam logic [3:0] ERR_COUNT_LOW   = 4'd10;
  localparam logic [3:0] ERR_OPEN_GROUP  = 4'd11;
  localparam logic [3:0] ERR_BAD_CHAR    = 4'd12;

  typedef struct packed {
    logic step;
    logic rep_rd;
    logic rep_wr;
    logic stat;
  } dlrp_cmd_t;

  typedef struct packed {
    logic out_free;
    logic end_req;
    logic replay;
    logic rep_done;
  } dlrp_stat_t;

  function automatic logic [4:0] hexval(input logic [7:0] c);
    logic [4:0] v;
    v = 5'd16;
    if (c >= "0" && c <= "9") v = 5'(c - "0");
    else if (c >= "a" && c <= "f") v = 5'(c - "a") + 5'd10;
    else if (c >= "A" && c <= "F") v = 5'(c - "A") + 5'd10;
    return v;
  endfunction

  function automatic logic is_blank(input logic [7:0] c);
    return (c == 8'h20) || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_x(input logic [7:0] c);
    return (c == "x") || (c == "X");
  endfunction

  function automatic logic in_range(input logic [7:0] v);
    return (v <= ENTRY_MAX) || (v == ENTRY_SPECIAL);
  endfunction

endpackage
`default_nettype wire

FILE: hw/rtl/dlrp_if.sv
// Interfaces: character input channel and result output channel.
`timescale 1ns / 1ps
`default_nettype none
interface dlrp_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] char_code;

  modport source (output valid, output req_type, output char_code, input ready);
  modport sink   (input valid, input req_type, input char_code, output ready);
endinterface

interface dlrp_out_if;
  logic       valid;
  logic       ready;
  logic       is_status;
  logic [7:0] entry_value;
  logic [3:0] status_code;
  logic [6:0] entry_count;
  logic       last_of_run;

  modport source (output valid, output is_status, output entry_value, output status_code,
                  output entry_count, output last_of_run, input ready);
  modport sink   (input valid, input is_status, input entry_value, input status_code,
                  input entry_count, input last_of_run, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/delay_list_repeat_parser_unit.sv
// Top level: delay list parser with repeat groups, controller plus datapath.
//
// in_ch carries one item per character (req_type 0) or the end of the string
// (req_type 1). out_ch carries stored list entries and, for the end item, one
// status item with the error code and entry count; last_of_run marks the
// final result caused by an input item.
// A character's entry, if any, sits in the output register the cycle after
// the character is taken. A closing brace replays its group through the
// single-port entry store, each replayed entry a read, then a write and emit.
// The end item emits a pending entry, if any, then the status item. A new
// item is taken only while the controller is idle and the output register
// is empty or being drained. Reset (synchronous, active low) returns the
// parser to the start of a list and empties the output register; the entry
// store needs no clearing pass. When out_ch stalls, the result stays in the
// output register and intake or replay waits until it is taken.
`timescale 1ns / 1ps
`default_nettype none
module delay_list_repeat_parser_unit #(
  parameter int ENTRY_LIMIT = 64
) (
  input wire logic  clk,
  input wire logic  rst_n,
  dlrp_in_if.sink   in_ch,
  dlrp_out_if.source out_ch
);
  import dlrp_pkg::*;

  dlrp_cmd_t  cmd;
  dlrp_stat_t st;

  dlrp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .st       (st),
    .cmd      (cmd)
  );

  dlrp_datapath #(
    .ENTRY_LIMIT (ENTRY_LIMIT)
  ) u_datapath (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .st              (st),
    .in_req_type     (in_ch.req_type),
    .in_char_code    (in_ch.char_code),
    .out_ready       (out_ch.ready),
    .out_valid       (out_ch.valid),
    .out_is_status   (out_ch.is_status),
    .out_entry_value (out_ch.entry_value),
    .out_status_code (out_ch.status_code),
    .out_entry_count (out_ch.entry_count),
    .out_last_of_run (out_ch.last_of_run)
  );

endmodule
`default_nettype wire

FILE: hw/rtl/dlrp_ctrl.sv
// Controller: sequences item intake, group replay and the status item.
`timescale 1ns / 1ps
`default_nettype none
module dlrp_ctrl (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire dlrp_pkg::dlrp_stat_t st,
  output dlrp_pkg::dlrp_cmd_t      cmd
);
  import dlrp_pkg::*;

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_REP_RD = 2'd1;
  localparam logic [1:0] S_REP_WR = 2'd2;
  localparam logic [1:0] S_STATUS = 2'd3;

  logic [1:0] state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = st.out_free;
        if (in_valid && st.out_free) begin
          cmd.step = 1'b1;
          if (st.end_req) state_nxt = S_STATUS;
          else if (st.replay) state_nxt = S_REP_RD;
        end
      end
      S_REP_RD: begin
        cmd.rep_rd = 1'b1;
        state_nxt  = S_REP_WR;
      end
      S_REP_WR: begin
        if (st.out_free) begin
          cmd.rep_wr = 1'b1;
          state_nxt  = st.rep_done ? S_IDLE : S_REP_RD;
        end
      end
      S_STATUS: begin
        if (st.out_free) begin
          cmd.stat  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/dlrp_datapath.sv
// Datapath: character scanner, entry store, replay counters and output register.
`timescale 1ns / 1ps
`default_nettype none
module dlrp_datapath #(
  parameter int ENTRY_LIMIT = 64
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire dlrp_pkg::dlrp_cmd_t cmd,
  output dlrp_pkg::dlrp_stat_t     st,
  input  wire logic                in_req_type,
  input  wire logic [7:0]          in_char_code,
  input  wire logic                out_ready,
  output logic                     out_valid,
  output logic                     out_is_status,
  output logic [7:0]               out_entry_value,
  output logic [3:0]               out_status_code,
  output logic [6:0]               out_entry_count,
  output logic                     out_last_of_run
);
  import dlrp_pkg::*;

  localparam int LIMIT = (ENTRY_LIMIT < STORE_DEPTH) ? ENTRY_LIMIT : STORE_DEPTH;
  localparam logic [CW-1:0] LIMIT_C = CW'(LIMIT);

  logic [1:0]    phase_r, phase_nxt;
  logic [2:0]    tok_r, tok_nxt;
  logic          gopen_r, gopen_nxt;
  logic [7:0]    acc_r, acc_nxt;
  logic [1:0]    base_r, base_nxt;
  logic [1:0]    pfx_r, pfx_nxt;
  logic [7:0]    rep_r, rep_nxt;
  logic [CW-1:0] gstart_r, gstart_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          err_r, err_nxt;
  logic [3:0]    ecode_r, ecode_nxt;

  logic [7:0]    copies_r;
  logic [CW-1:0] idx_r;
  logic [CW-1:0] len_r;
  logic [7:0]    rd_data_r;
  logic [7:0]    store_mem [STORE_DEPTH];

  logic          out_valid_r;
  logic          out_is_status_r;
  logic [7:0]    out_value_r;
  logic [3:0]    out_code_r;
  logic [6:0]    out_count_r;
  logic          out_last_r;

  logic [7:0]  c;
  logic [4:0]  hv;
  logic [4:0]  radix;
  logic [11:0] t;
  logic        go_after, do_store, close_store, store_ok, fail_en, replay;
  logic [3:0]  fail_code;
  logic [7:0]  store_val;
  logic        step_last;

  always_comb begin
    c           = in_char_code;
    hv          = hexval(c);
    radix       = (base_r == BASE_HEX) ? 5'd16 : ((base_r == BASE_OCT) ? 5'd8 : 5'd10);
    t           = 12'(acc_r) * 12'(radix) + 12'(hv);
    phase_nxt   = phase_r;
    tok_nxt     = tok_r;
    gopen_nxt   = gopen_r;
    acc_nxt     = acc_r;
    base_nxt    = base_r;
    pfx_nxt     = pfx_r;
    rep_nxt     = rep_r;
    gstart_nxt  = gstart_r;
    cnt_nxt     = cnt_r;
    err_nxt     = err_r;
    ecode_nxt   = ecode_r;
    go_after    = 1'b0;
    do_store    = 1'b0;
    close_store = 1'b0;
    store_ok    = 1'b0;
    fail_en     = 1'b0;
    fail_code   = ERR_OK;
    store_val   = acc_r;

    if (!err_r) begin
      if (in_req_type == REQ_CHAR) begin
        case (phase_r)
          PH_EXPECT: begin
            if (!is_blank(c)) begin
              if (hv < 5'd10) begin
                base_nxt  = BASE_DEC;
                acc_nxt   = 8'(hv);
                pfx_nxt   = (hv == 5'd0) ? PF_ZERO : PF_DIGITS;
                phase_nxt = PH_NUMBER;
              end else if (hv < 5'd16) begin
                fail_en = 1'b1; fail_code = ERR_BAD_NUMBER;
              end else if (c == CH_COMMA) begin
                fail_en = 1'b1; fail_code = ERR_COMMA;
              end else if (c == CH_OPEN) begin
                fail_en = 1'b1; fail_code = ERR_NO_COUNT;
              end else if (c == CH_CLOSE) begin
                fail_en = 1'b1;
                if (!gopen_r) fail_code = ERR_CLOSE;
                else if (tok_r == TK_OPEN) fail_code = ERR_EMPTY_GROUP;
                else fail_code = ERR_TRAILING;
              end else begin
                fail_en = 1'b1; fail_code = ERR_BAD_CHAR;
              end
            end
          end
          PH_NUMBER: begin
            if (pfx_r == PF_ZERO) begin
              if (is_x(c)) begin
                base_nxt = BASE_HEX;
                pfx_nxt  = PF_HEXWAIT;
              end else if (hv < 5'd8) begin
                base_nxt = BASE_OCT;
                acc_nxt  = 8'(hv);
                pfx_nxt  = PF_DIGITS;
              end else if (hv < 5'd16) begin
                fail_en = 1'b1; fail_code = ERR_BAD_NUMBER;
              end else begin
                go_after = 1'b1;
              end
            end else if (pfx_r == PF_HEXWAIT) begin
              if (hv < 5'd16) begin
                acc_nxt = 8'(hv);
                pfx_nxt = PF_DIGITS;
              end else begin
                // a lone 0x prefix is a bad number however it ends
                fail_en = 1'b1; fail_code = ERR_BAD_NUMBER;
              end
            end else begin
              if (hv < radix) begin
                acc_nxt = (t > 12'd255) ? 8'hFF : t[7:0];
              end else if (hv < 5'd16 || is_x(c)) begin
                fail_en = 1'b1; fail_code = ERR_BAD_NUMBER;
              end else begin
                go_after = 1'b1;
              end
            end
            if (go_after) begin
              pfx_nxt   = PF_NONE;
              tok_nxt   = TK_DIGIT;
              phase_nxt = PH_AFTER_NUM;
            end
          end
          PH_AFTER_NUM: go_after = 1'b1;
          default: begin
            if (!is_blank(c)) begin
              if (c == CH_COMMA) begin
                tok_nxt   = TK_COMMA;
                phase_nxt = PH_EXPECT;
              end else if (c == CH_CLOSE) begin
                fail_en = 1'b1; fail_code = ERR_CLOSE;
              end else if (hv < 5'd16 || c == CH_OPEN) begin
                fail_en = 1'b1; fail_code = ERR_NO_COMMA;
              end else begin
                fail_en = 1'b1; fail_code = ERR_BAD_CHAR;
              end
            end
          end
        endcase

        if (go_after && !is_blank(c)) begin
          if (c == CH_COMMA) begin
            do_store  = 1'b1;
            tok_nxt   = TK_COMMA;
            phase_nxt = PH_EXPECT;
          end else if (c == CH_OPEN) begin
            if (gopen_r) begin
              fail_en = 1'b1; fail_code = ERR_NO_COMMA;
            end else if (acc_r == 8'd0) begin
              fail_en = 1'b1; fail_code = ERR_COUNT_LOW;
            end else begin
              rep_nxt    = acc_r;
              gstart_nxt = cnt_r;
              gopen_nxt  = 1'b1;
              tok_nxt    = TK_OPEN;
              phase_nxt  = PH_EXPECT;
            end
          end else if (c == CH_CLOSE) begin
            if (!gopen_r) begin
              fail_en = 1'b1; fail_code = ERR_CLOSE;
            end else begin
              do_store    = 1'b1;
              close_store = 1'b1;
              gopen_nxt   = 1'b0;
              tok_nxt     = TK_CLOSE;
              phase_nxt   = PH_AFTER_CLOSE;
            end
          end else if (hv < 5'd16) begin
            fail_en = 1'b1; fail_code = ERR_NO_COMMA;
          end else begin
            fail_en = 1'b1; fail_code = ERR_BAD_CHAR;
          end
        end
      end else begin
        if (phase_r == PH_NUMBER && pfx_r == PF_HEXWAIT) begin
          fail_en = 1'b1; fail_code = ERR_BAD_NUMBER;
        end else if (phase_r == PH_NUMBER || phase_r == PH_AFTER_NUM) begin
          if (gopen_r) begin
            fail_en = 1'b1; fail_code = ERR_OPEN_GROUP;
          end else begin
            do_store = 1'b1;
          end
        end else if (gopen_r) begin
          fail_en = 1'b1; fail_code = ERR_OPEN_GROUP;
        end else if (tok_r == TK_COMMA) begin
          fail_en = 1'b1; fail_code = ERR_TRAILING;
        end
      end
    end

    if (do_store) begin
      if (!in_range(store_val)) begin
        fail_en = 1'b1; fail_code = ERR_RANGE;
      end else if (cnt_r >= LIMIT_C) begin
        fail_en = 1'b1; fail_code = ERR_TOO_MANY;
      end else begin
        store_ok = 1'b1;
        cnt_nxt  = cnt_r + CW'(1);
      end
    end
    if (fail_en) begin
      err_nxt   = 1'b1;
      ecode_nxt = fail_code;
    end
  end

  assign replay    = close_store && store_ok && (rep_r > 8'd1);
  assign step_last = (in_req_type == REQ_END) ? 1'b0
                   : !(replay && (({1'b0, cnt_r} + 8'(1)) < {1'b0, LIMIT_C}));

  logic          idx_last, rep_final, rep_full, rep_last;
  logic [AW-1:0] rd_addr;
  logic          load_entry, mem_we;
  logic [7:0]    mem_wd;

  assign idx_last   = (idx_r + CW'(1)) == len_r;
  assign rep_final  = idx_last && (copies_r == 8'd1);
  assign rep_full   = cnt_r >= LIMIT_C;
  assign rep_last   = rep_final || (({1'b0, cnt_r} + 8'(1)) >= {1'b0, LIMIT_C});
  assign rd_addr    = AW'(gstart_r + idx_r);
  assign load_entry = (cmd.step && store_ok) || (cmd.rep_wr && !rep_full);
  assign mem_we     = load_entry;
  assign mem_wd     = cmd.rep_wr ? rd_data_r : store_val;

  assign st.out_free = !out_valid_r || out_ready;
  assign st.end_req  = (in_req_type == REQ_END);
  assign st.replay   = replay;
  assign st.rep_done = rep_full || rep_final;

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.stat) begin
      phase_r  <= PH_EXPECT;
      tok_r    <= TK_NONE;
      gopen_r  <= 1'b0;
      acc_r    <= 8'd0;
      base_r   <= BASE_DEC;
      pfx_r    <= PF_NONE;
      rep_r    <= 8'd0;
      gstart_r <= '0;
      cnt_r    <= '0;
      err_r    <= 1'b0;
      ecode_r  <= ERR_OK;
    end else if (cmd.step) begin
      phase_r  <= phase_nxt;
      tok_r    <= tok_nxt;
      gopen_r  <= gopen_nxt;
      acc_r    <= acc_nxt;
      base_r   <= base_nxt;
      pfx_r    <= pfx_nxt;
      rep_r    <= rep_nxt;
      gstart_r <= gstart_nxt;
      cnt_r    <= cnt_nxt;
      err_r    <= err_nxt;
      ecode_r  <= ecode_nxt;
    end else if (cmd.rep_wr) begin
      if (rep_full) begin
        err_r   <= 1'b1;
        ecode_r <= ERR_TOO_MANY;
      end else begin
        cnt_r <= cnt_r + CW'(1);
      end
    end
  end

  // replay bookkeeping: copies left and position inside the group
  always_ff @(posedge clk) begin
    if (cmd.step && replay) begin
      copies_r <= rep_r - 8'd1;
      idx_r    <= '0;
      len_r    <= cnt_r - gstart_r + CW'(1);
    end else if (cmd.rep_wr && !rep_full) begin
      if (idx_last) begin
        idx_r    <= '0;
        copies_r <= copies_r - 8'd1;
      end else begin
        idx_r <= idx_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) store_mem[cnt_r[AW-1:0]] <= mem_wd;
    if (cmd.rep_rd) rd_data_r <= store_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (load_entry || cmd.stat) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_entry) begin
      out_is_status_r <= 1'b0;
      out_value_r     <= mem_wd;
      out_code_r      <= ERR_OK;
      out_count_r     <= 7'd0;
      out_last_r      <= cmd.rep_wr ? rep_last : step_last;
    end else if (cmd.stat) begin
      out_is_status_r <= 1'b1;
      out_value_r     <= 8'd0;
      out_code_r      <= err_r ? ecode_r : ERR_OK;
      out_count_r     <= err_r ? 7'd0 : 7'(cnt_r);
      out_last_r      <= 1'b1;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_is_status   = out_is_status_r;
  assign out_entry_value = out_value_r;
  assign out_status_code = out_code_r;
  assign out_entry_count = out_count_r;
  assign out_last_of_run = out_last_r;

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= LIMIT_C)
    else $error("entry count past limit");

  a_stat_clears: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.stat |=> (cnt_r == '0) && !err_r && !gopen_r && (phase_r == PH_EXPECT))
    else $error("parser state not cleared after status item");

  a_no_store_after_err: assert property (@(posedge clk) disable iff (!rst_n)
    (err_r && cmd.step) |-> !store_ok)
    else $error("entry stored after latched error");

  a_replay_src: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rep_wr && !rep_full) |-> (({1'b0, gstart_r} + {1'b0, idx_r}) < {1'b0, cnt_r}))
    else $error("replay reads an entry not yet stored");

endmodule
`default_nettype wire
